>>> hdl/ght_pkg.sv
// Shared types, constants and a helper function for the generational handle table.
`timescale 1ns / 1ps

package ght_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int SLOT_BITS = 20;
    localparam int GEN_W     = 12;
    localparam int KIND_W    = 3;
    localparam int PAY_W     = 32;
    localparam int HANDLE_W  = 32;
    localparam int MODE_W    = 2;
    localparam int KIND_MAX  = 4;
    localparam int BMAP_W    = 32;
    localparam int BMAP_LW   = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_RD,
        ST_APP_WR,
        ST_SLOT_RD,
        ST_CHK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_GEN_RD,
        ST_GEN_WR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              occ;
        logic [GEN_W-1:0]  gen;
        logic [KIND_W-1:0] kind;
        logic [PAY_W-1:0]  payload;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                ok;
        logic [KIND_W-1:0]   kind_out;
        logic [PAY_W-1:0]    payload_out;
    } t_result;

    // Position of the lowest set bit of a bitmap word; zero when the word is empty.
    function automatic logic [BMAP_LW-1:0] find_first(input logic [BMAP_W-1:0] w);
        logic [BMAP_LW-1:0] pos;
        pos = '0;
        for (int i = BMAP_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BMAP_LW'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> hdl/ght_if.sv
// Valid/ready channel interfaces for the request and result items.
`timescale 1ns / 1ps

interface ght_in_if import ght_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle_in;
    logic [KIND_W-1:0]   kind;
    logic [PAY_W-1:0]    payload;

    modport source (output valid, output mode, output handle_in, output kind,
                    output payload, input ready);
    modport sink   (input valid, input mode, input handle_in, input kind,
                    input payload, output ready);
endinterface

interface ght_out_if import ght_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] handle_out;
    logic                ok;
    logic [KIND_W-1:0]   kind_out;
    logic [PAY_W-1:0]    payload_out;

    modport source (output valid, output handle_out, output ok, output kind_out,
                    output payload_out, input ready);
    modport sink   (input valid, input handle_out, input ok, input kind_out,
                    input payload_out, output ready);
endinterface

>>> hdl/ght_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module ght_ram import ght_pkg::*; #(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/generational_handle_table_core.sv
// Generational handle table: slot memory, free-slot bitmap and the sequencer.
// A rejected request goes straight to the result. Lookup reads and checks its slot; append
// writes the new slot and clears its bitmap bit; a free with a matching handle writes the slot
// back and, when the slot stays reusable, sets its bitmap bit; a reusing allocate scans bitmap
// words from the hint, then reads and rewrites the slot. One item is in flight at a time; the
// next is accepted only after the result is loaded. Synchronous active-low reset clears the
// sequencer, the slot counters, the scan hint and the output valid; the memories are not cleared.
`timescale 1ns / 1ps

module generational_handle_table_core import ght_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ght_in_if.sink      i_in,
    ght_out_if.source   o_out
);

    // Derived sizes. The bitmap holds one bit per slot, set while the slot is
    // free and still has a usable (nonzero) generation.
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORDS   = (SLOTS + BMAP_W - 1) / BMAP_W;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    t_state r_state, n_state;

    // Held request fields.
    logic [MODE_W-1:0]   r_mode;
    logic [HANDLE_W-1:0] r_hin;
    logic [KIND_W-1:0]   r_kind;
    logic [PAY_W-1:0]    r_pay;

    // Table bookkeeping. r_count is the number of slots ever appended, r_reuse the
    // number of reusable slots, and r_hint a word index at or below the lowest
    // bitmap word that may hold a reusable slot.
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_reuse;
    logic [WORD_AW-1:0] r_hint;
    logic [WORD_AW-1:0] r_ptr;
    logic [SLOT_AW-1:0] r_idx;

    t_result r_res;
    t_result r_out;
    logic    r_ov;

    // Memory ports.
    logic               s_we;
    logic [SLOT_AW-1:0] s_waddr;
    t_slot_entry        s_wdata;
    logic [SLOT_AW-1:0] s_raddr;
    t_slot_entry        s_rdata;

    logic               b_we;
    logic [WORD_AW-1:0] b_waddr;
    logic [BMAP_W-1:0]  b_wdata;
    logic [WORD_AW-1:0] b_raddr;
    logic [BMAP_W-1:0]  b_rdata;

    ght_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (SLOT_AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    ght_ram #(
        .WIDTH (BMAP_W),
        .DEPTH (WORDS),
        .AW    (WORD_AW)
    ) u_bmap_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // ------------------------------------------------------------------
    // Request decode, done while idle on the live input fields.
    // ------------------------------------------------------------------
    logic                 in_fire;
    logic [SLOT_BITS-1:0] in_n;
    logic                 in_n_ok;
    logic                 in_kind_ok;
    logic                 tbl_full;

    assign in_fire    = i_in.valid && i_in.ready;
    assign in_n       = i_in.handle_in[SLOT_BITS-1:0];
    // A slot number is in range when it is nonzero and names an appended slot.
    assign in_n_ok    = (in_n != '0) &&
                        ({1'b0, in_n} <= (SLOT_BITS + 1)'(r_count));
    assign in_kind_ok = (i_in.kind != '0) && (i_in.kind <= KIND_W'(KIND_MAX));
    assign tbl_full   = (r_count == CNT_W'(SLOTS));

    // ------------------------------------------------------------------
    // Datapath terms on the held request and the memory read data.
    // ------------------------------------------------------------------
    logic [GEN_W-1:0]   held_gen;
    logic               chk_valid;
    logic [GEN_W-1:0]   new_gen;
    logic [WORD_AW-1:0] idx_word;
    logic [BMAP_LW-1:0] idx_bit;
    logic [WORD_AW-1:0] cnt_word;
    logic [BMAP_LW-1:0] cnt_bit;
    logic [SLOT_AW-1:0] app_idx;
    logic [BMAP_W-1:0]  scan_mask;
    logic [BMAP_W-1:0]  scan_word;
    logic               scan_hit;
    logic [BMAP_LW-1:0] scan_bit;
    logic [SLOT_AW-1:0] scan_idx;

    assign held_gen  = r_hin[HANDLE_W-1:SLOT_BITS];
    assign chk_valid = s_rdata.occ && (s_rdata.gen == held_gen);
    // The 12-bit increment wraps the maximum generation to zero, which retires the slot.
    assign new_gen   = s_rdata.gen + GEN_W'(1);
    assign idx_word  = WORD_AW'(r_idx >> BMAP_LW);
    assign idx_bit   = BMAP_LW'(r_idx);
    assign cnt_word  = WORD_AW'(r_count >> BMAP_LW);
    assign cnt_bit   = BMAP_LW'(r_count);
    assign app_idx   = SLOT_AW'(r_count);

    // Bits at or beyond the appended count were never written and are masked off.
    always_comb begin
        if ((SLOT_BITS + 1)'(r_ptr) < (SLOT_BITS + 1)'(r_count >> BMAP_LW)) begin
            scan_mask = '1;
        end else if ((SLOT_BITS + 1)'(r_ptr) == (SLOT_BITS + 1)'(r_count >> BMAP_LW)) begin
            scan_mask = (BMAP_W'(1) << cnt_bit) - BMAP_W'(1);
        end else begin
            scan_mask = '0;
        end
    end

    assign scan_word = b_rdata & scan_mask;
    assign scan_hit  = |scan_word;
    assign scan_bit  = find_first(scan_word);
    assign scan_idx  = SLOT_AW'({r_ptr, scan_bit});

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.mode)
                        MODE_ALLOC: begin
                            if (!in_kind_ok) begin
                                n_state = ST_OUT;
                            end else if (r_reuse != '0) begin
                                n_state = ST_SCAN_RD;
                            end else if (!tbl_full) begin
                                n_state = ST_APP_RD;
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                        MODE_FREE, MODE_LOOKUP: begin
                            n_state = in_n_ok ? ST_SLOT_RD : ST_OUT;
                        end
                        default: begin
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_APP_RD:  n_state = ST_APP_WR;
            ST_APP_WR:  n_state = ST_OUT;
            ST_SLOT_RD: n_state = ST_CHK;
            ST_CHK: begin
                if ((r_mode == MODE_FREE) && chk_valid && (new_gen != '0)) begin
                    n_state = ST_FREE_RD;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_FREE_RD:  n_state = ST_FREE_WR;
            ST_FREE_WR:  n_state = ST_OUT;
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: n_state = scan_hit ? ST_GEN_RD : ST_SCAN_RD;
            ST_GEN_RD:   n_state = ST_GEN_WR;
            ST_GEN_WR:   n_state = ST_OUT;
            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Memory control. Every read-modify-write reads in one state and writes
    // in the next, and only one item is ever in flight, so reads and writes
    // to the same entry never overlap.
    // ------------------------------------------------------------------
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_idx;
        s_wdata = '0;
        s_raddr = r_idx;
        b_we    = 1'b0;
        b_waddr = r_ptr;
        b_wdata = '0;
        b_raddr = r_ptr;
        unique case (r_state)
            ST_APP_RD: begin
                // A new slot starts at generation one and is occupied at once.
                s_we    = 1'b1;
                s_waddr = app_idx;
                s_wdata = '{occ: 1'b1, gen: GEN_W'(1), kind: r_kind, payload: r_pay};
                b_raddr = cnt_word;
            end
            ST_APP_WR: begin
                b_we    = 1'b1;
                b_waddr = cnt_word;
                b_wdata = b_rdata & ~(BMAP_W'(1) << cnt_bit);
            end
            ST_CHK: begin
                if ((r_mode == MODE_FREE) && chk_valid) begin
                    s_we    = 1'b1;
                    s_wdata = '{occ: 1'b0, gen: new_gen, kind: s_rdata.kind,
                                payload: s_rdata.payload};
                end
            end
            ST_FREE_RD: begin
                b_raddr = idx_word;
            end
            ST_FREE_WR: begin
                b_we    = 1'b1;
                b_waddr = idx_word;
                b_wdata = b_rdata | (BMAP_W'(1) << idx_bit);
            end
            ST_SCAN_CHK: begin
                if (scan_hit) begin
                    b_we    = 1'b1;
                    b_wdata = b_rdata & ~(BMAP_W'(1) << scan_bit);
                end
            end
            ST_GEN_WR: begin
                s_we    = 1'b1;
                s_wdata = '{occ: 1'b1, gen: s_rdata.gen, kind: r_kind, payload: r_pay};
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_reuse <= '0;
            r_hint  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_APP_WR) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == ST_FREE_WR) begin
                r_reuse <= r_reuse + CNT_W'(1);
                if (idx_word < r_hint) begin
                    r_hint <= idx_word;
                end
            end
            // Words below the one just hit hold no reusable slot.
            if ((r_state == ST_SCAN_CHK) && scan_hit) begin
                r_reuse <= r_reuse - CNT_W'(1);
                r_hint  <= r_ptr;
            end
            if ((r_state == ST_OUT) && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_mode <= i_in.mode;
                    r_hin  <= i_in.handle_in;
                    r_kind <= i_in.kind;
                    r_pay  <= i_in.payload;
                    r_idx  <= SLOT_AW'(in_n - SLOT_BITS'(1));
                    r_ptr  <= r_hint;
                    r_res  <= '0;
                end
            end
            ST_APP_WR: begin
                r_res.handle_out <= {GEN_W'(1), SLOT_BITS'(r_count) + SLOT_BITS'(1)};
                r_res.ok         <= 1'b1;
            end
            ST_CHK: begin
                if (chk_valid) begin
                    r_res.ok          <= 1'b1;
                    r_res.kind_out    <= s_rdata.kind;
                    r_res.payload_out <= s_rdata.payload;
                end
            end
            ST_SCAN_CHK: begin
                if (scan_hit) begin
                    r_idx <= scan_idx;
                end else begin
                    r_ptr <= r_ptr + WORD_AW'(1);
                end
            end
            ST_GEN_WR: begin
                r_res.handle_out <= {s_rdata.gen, SLOT_BITS'(r_idx) + SLOT_BITS'(1)};
                r_res.ok         <= 1'b1;
            end
            default: begin
            end
        endcase
        if ((r_state == ST_OUT) && (!r_ov || o_out.ready)) begin
            r_out <= r_res;
        end
    end

    // ------------------------------------------------------------------
    // Channel ports.
    // ------------------------------------------------------------------
    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.handle_out  = r_out.handle_out;
    assign o_out.ok          = r_out.ok;
    assign o_out.kind_out    = r_out.kind_out;
    assign o_out.payload_out = r_out.payload_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Reusable slots are a subset of the appended ones.
    a_reuse_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reuse <= r_count)
        else $error("reusable count exceeds appended count");

    // A bitmap scan only starts when a reusable slot is known to exist.
    a_scan_has_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_CHK) |-> (r_reuse != '0))
        else $error("bitmap scan with no reusable slot");

    // Slots are never removed from the appended range.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("appended slot count decreased");

    // A failed request reports all fields as zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |->
            ((o_out.handle_out == '0) && (o_out.kind_out == '0) &&
             (o_out.payload_out == '0)))
        else $error("failed result carries nonzero fields");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the generational handle table core.
`timescale 1ns / 1ps

module testbench;
    import ght_pkg::*;

    // Table size under test; the predictor keeps a table of the same depth.
    localparam int TABLE_SLOTS = SLOTS_DEF;
    // Mode code that the block leaves unused; it must change nothing and answer zeros.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Generous watchdog, several times the slowest legal run of about four hundred items.
    localparam int CYCLE_LIMIT = 400_000;
    // Keeps a badly broken block from flooding the log; every mismatch is still counted.
    localparam int MAX_REPORTS = 50;
    localparam int STALE_KEEP  = 64;

    logic i_clk;
    logic i_rst_n;

    ght_in_if  in_if ();
    ght_out_if out_if ();

    generational_handle_table_core #(
        .SLOTS(TABLE_SLOTS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predicted table contents: slots ever appended, and per slot the occupancy,
    // generation, kind and payload as the block should hold them.
    int unsigned        slots_appended;
    bit                 slot_busy [TABLE_SLOTS];
    logic [GEN_W-1:0]   slot_gen  [TABLE_SLOTS];
    logic [KIND_W-1:0]  slot_kind [TABLE_SLOTS];
    logic [PAY_W-1:0]   slot_data [TABLE_SLOTS];

    // Results that the table owes, oldest first.
    t_result predicted_replies [$];

    // Handles that should currently be valid, and handles that were freed.
    logic [HANDLE_W-1:0] live_handles  [$];
    logic [HANDLE_W-1:0] stale_handles [$];

    int mismatch_count = 0;
    // While set, neither side inserts idle cycles.
    bit calm_traffic   = 1'b0;

    // Applies one request to the predicted table and returns the answer it must give.
    function automatic t_result predict_table_op(input logic [MODE_W-1:0]   mode,
                                                 input logic [HANDLE_W-1:0] handle,
                                                 input logic [KIND_W-1:0]   kind,
                                                 input logic [PAY_W-1:0]    payload);
        t_result          reply;
        int unsigned      idx;
        int unsigned      num;
        logic [GEN_W-1:0] hgen;
        bit               found;
        reply = '0;
        idx   = 0;
        found = 1'b0;
        num   = handle[SLOT_BITS-1:0];
        hgen  = handle[HANDLE_W-1:SLOT_BITS];
        case (mode)
            MODE_ALLOC: begin
                if (kind >= 1 && kind <= KIND_MAX) begin
                    // The lowest free slot that has not been retired wins.
                    for (int i = 0; i < slots_appended; i++) begin
                        if (!found && !slot_busy[i] && slot_gen[i] != '0) begin
                            found = 1'b1;
                            idx   = i;
                        end
                    end
                    // Otherwise a fresh slot is appended at generation one.
                    if (!found && slots_appended < TABLE_SLOTS) begin
                        idx           = slots_appended;
                        slot_gen[idx] = GEN_W'(1);
                        slots_appended++;
                        found = 1'b1;
                    end
                    if (found) begin
                        slot_busy[idx]   = 1'b1;
                        slot_kind[idx]   = kind;
                        slot_data[idx]   = payload;
                        reply.handle_out = {slot_gen[idx], SLOT_BITS'(idx + 1)};
                        reply.ok         = 1'b1;
                    end
                end
            end
            MODE_FREE, MODE_LOOKUP: begin
                if (num != 0 && num <= slots_appended && num <= TABLE_SLOTS) begin
                    idx = num - 1;
                    if (slot_busy[idx] && slot_gen[idx] == hgen) begin
                        reply.ok          = 1'b1;
                        reply.kind_out    = slot_kind[idx];
                        reply.payload_out = slot_data[idx];
                        if (mode == MODE_FREE) begin
                            // From the top generation the slot wraps to zero and retires.
                            slot_busy[idx] = 1'b0;
                            slot_gen[idx]  = slot_gen[idx] + GEN_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] check failed: %s", $time, what);
        end
    endtask

    // Offers one item at a falling edge, waits for the handshake and books the prediction.
    // Valid stays high between back-to-back items so it is never lowered and raised at once.
    task automatic send_request(input  logic [MODE_W-1:0]   mode,
                                input  logic [HANDLE_W-1:0] handle,
                                input  logic [KIND_W-1:0]   kind,
                                input  logic [PAY_W-1:0]    payload,
                                output t_result             reply);
        int pos;
        pos = -1;
        @(negedge i_clk);
        while (!calm_traffic && $urandom_range(0, 99) < 36) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.handle_in <= handle;
        in_if.kind      <= kind;
        in_if.payload   <= payload;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        reply = predict_table_op(mode, handle, kind, payload);
        predicted_replies.push_back(reply);
        // Keep the handle pools in step so later items can aim at real objects.
        if (mode == MODE_ALLOC && reply.ok) begin
            live_handles.push_back(reply.handle_out);
        end else if (mode == MODE_FREE && reply.ok) begin
            foreach (live_handles[i]) begin
                if (pos < 0 && live_handles[i] == handle) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                live_handles.delete(pos);
            end
            stale_handles.push_back(handle);
            if (stale_handles.size() > STALE_KEEP) begin
                void'(stale_handles.pop_front());
            end
        end
    endtask

    // The result side: a random ready at each falling edge, checks at each rising edge.
    always @(negedge i_clk) begin
        out_if.ready <= calm_traffic || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("result arrived with nothing outstanding");
            end else begin
                want = predicted_replies.pop_front();
                if (out_if.handle_out !== want.handle_out) begin
                    report_mismatch($sformatf("handle_out got %h want %h",
                                              out_if.handle_out, want.handle_out));
                end
                if (out_if.ok !== want.ok) begin
                    report_mismatch($sformatf("ok got %b want %b", out_if.ok, want.ok));
                end
                if (out_if.kind_out !== want.kind_out) begin
                    report_mismatch($sformatf("kind_out got %0d want %0d",
                                              out_if.kind_out, want.kind_out));
                end
                if (out_if.payload_out !== want.payload_out) begin
                    report_mismatch($sformatf("payload_out got %h want %h",
                                              out_if.payload_out, want.payload_out));
                end
            end
        end
    end

    // Hand-picked items: empty-table lookups, invalid kinds, payload extremes, stale and
    // mismatched handles, double free, reuse of a freed slot and the unused mode.
    task automatic test_directed_cases();
        t_result             r;
        logic [HANDLE_W-1:0] h_a;
        logic [HANDLE_W-1:0] h_b;
        logic [HANDLE_W-1:0] h_c;
        logic [HANDLE_W-1:0] h_d;
        send_request(MODE_LOOKUP, '0, 3'd1, '0, r);
        send_request(MODE_FREE, '1, 3'd7, '1, r);
        send_request(MODE_ALLOC, '1, 3'd0, 32'h0000_0001, r);
        send_request(MODE_ALLOC, '0, 3'd5, 32'h0000_0002, r);
        send_request(MODE_ALLOC, '0, 3'd7, 32'h0000_0003, r);
        // A zero payload is legal: occupancy lives in its own bit.
        send_request(MODE_ALLOC, '0, 3'd1, 32'h0000_0000, r);
        h_a = r.handle_out;
        send_request(MODE_ALLOC, '1, 3'd4, 32'hFFFF_FFFF, r);
        h_b = r.handle_out;
        send_request(MODE_ALLOC, '0, 3'd2, 32'h1234_5678, r);
        h_c = r.handle_out;
        send_request(MODE_LOOKUP, h_a, 3'd0, '1, r);
        send_request(MODE_LOOKUP, h_a ^ (32'h1 << SLOT_BITS), 3'd0, '0, r);
        send_request(MODE_LOOKUP, {h_a[HANDLE_W-1:SLOT_BITS], SLOT_BITS'(0)}, 3'd0, '0, r);
        send_request(MODE_LOOKUP, {GEN_W'(1), SLOT_BITS'(slots_appended + 1)}, 3'd0, '0, r);
        send_request(MODE_FREE, h_b, 3'd3, '0, r);
        send_request(MODE_FREE, h_b, 3'd3, '0, r);
        send_request(MODE_LOOKUP, h_b, 3'd0, '0, r);
        // The freed slot comes back with the next generation.
        send_request(MODE_ALLOC, '0, 3'd3, 32'hA5A5_A5A5, r);
        h_d = r.handle_out;
        send_request(MODE_LOOKUP, h_d, 3'd6, '0, r);
        send_request(MODE_UNUSED, h_a, 3'd2, '1, r);
        send_request(MODE_LOOKUP, h_a, 3'd0, '0, r);
        send_request(MODE_FREE, h_c, 3'd0, '0, r);
        send_request(MODE_FREE, h_a, 3'd0, '0, r);
        send_request(MODE_ALLOC, '1, 3'd4, 32'h8000_0001, r);
    endtask

    // Mostly well-formed traffic on real handles, with stale, forged and garbage handles,
    // invalid kinds and the unused mode mixed in. The pool is kept to a few dozen objects
    // so that appends, reuse across bitmap words and frees all keep happening.
    task automatic test_random_traffic(input int count);
        t_result             r;
        int                  pick;
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [KIND_W-1:0]   kind;
        logic [PAY_W-1:0]    payload;
        for (int n = 0; n < count; n++) begin
            pick    = $urandom_range(0, 99);
            handle  = $urandom;
            kind    = $urandom_range(0, 7);
            payload = $urandom;
            if (live_handles.size() > 48 && pick < 30) begin
                pick = 30;
            end
            if (live_handles.size() == 0 || pick < 30 ||
                (live_handles.size() < 8 && pick < 50)) begin
                mode = MODE_ALLOC;
                kind = $urandom_range(1, KIND_MAX);
                if ($urandom_range(0, 9) == 0) begin
                    kind = $urandom_range(0, 3);
                    kind = (kind == 0) ? 3'd0 : kind + 3'd4;
                end
                case ($urandom_range(0, 15))
                    0: payload = '0;
                    1: payload = '1;
                    default: begin
                    end
                endcase
            end else if (pick < 80) begin
                mode   = (pick < 55) ? MODE_FREE : MODE_LOOKUP;
                handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
            end else if (pick < 88) begin
                mode = $urandom_range(0, 1) ? MODE_FREE : MODE_LOOKUP;
                if (stale_handles.size() != 0) begin
                    handle = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
                end
            end else if (pick < 95) begin
                mode = $urandom_range(0, 1) ? MODE_FREE : MODE_LOOKUP;
                case ($urandom_range(0, 3))
                    0: handle[SLOT_BITS-1:0] = '0;
                    1: handle[SLOT_BITS-1:0] =
                           SLOT_BITS'($urandom_range(slots_appended + 1, (1 << SLOT_BITS) - 1));
                    2: handle = live_handles[$urandom_range(0, live_handles.size() - 1)] ^
                                (32'h1 << (SLOT_BITS + $urandom_range(0, GEN_W - 1)));
                    default: begin
                    end
                endcase
            end else begin
                mode = MODE_UNUSED;
                if ($urandom_range(0, 1) && live_handles.size() != 0) begin
                    handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
                end
            end
            send_request(mode, handle, kind, payload, r);
        end
    endtask

    // The same mix of traffic with neither side idling, so items and results run
    // back to back for a long stretch.
    task automatic test_back_to_back_traffic(input int count);
        calm_traffic = 1'b1;
        test_random_traffic(count);
        calm_traffic = 1'b0;
    endtask

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.mode      = '0;
        in_if.handle_in = '0;
        in_if.kind      = '0;
        in_if.payload   = '0;
        out_if.ready    = 1'b0;
        slots_appended  = 0;
        foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            slot_gen[i]  = '0;
            slot_kind[i] = '0;
            slot_data[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(280);
        test_back_to_back_traffic(100);

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (predicted_replies.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray extra result show up before the verdict.
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
